// File: hdl/matrix3x3_inverse_defines.svh
// ------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// shared property forms for the checker of the 3x3 matrix inverse block
// ------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define M3_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with a fixed delay, disabled during reset
`define M3_CHECK_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// File: hdl/m3inv_pkg.sv
// ------------------------------------------------------------------------
// m3inv_pkg
// widths, pipeline depth and stage types of the 3x3 matrix inverse
// ------------------------------------------------------------------------
package m3inv_pkg;

    // number format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // exact intermediate widths
    localparam int PROD_W = 2 * DATA_W;        // element products
    localparam int COF_W  = PROD_W + 1;        // cofactors, signed
    localparam int MAG_W  = PROD_W;            // cofactor magnitude
    localparam int DET_W  = MAG_W + DATA_W + 1 + 1; // signed determinant
    localparam int DMAG_W = DET_W - 1;
    localparam int D2_W   = DMAG_W + 1;        // twice the magnitude
    localparam int NSH    = 2 * FRAC_BITS + 1;

    // divider: one quotient bit per stage
    localparam int QB     = DATA_W + 1;
    localparam int WIDE   = D2_W + QB;

    // front stages, divider setup, divider stages, output register
    localparam int FRONT   = 7;
    localparam int LATENCY = FRONT + 1 + QB + 1;

    localparam int NELEM = 9;

    typedef struct packed {
        logic [NELEM-1:0][WIDE-1:0] rem;
        logic [NELEM-1:0][QB-1:0]   quo;
        logic [NELEM-1:0]           big;
        logic [NELEM-1:0]           ineg;
        logic [D2_W-1:0]            d2;
        logic                       dneg;
        logic [DATA_W-1:0]          det_q;
        logic                       det_ov;
        logic                       sing;
    } div_stage_t;

endpackage

// File: hdl/matrix3x3_inverse.sv
// ------------------------------------------------------------------------
// matrix3x3_inverse
// pipelined general inverse of a signed fixed-point 3x3 matrix
// ------------------------------------------------------------------------
// usage:
//   raise start with the nine elements a00..a22 (row-major, signed Q16.16);
//   the transaction is taken at any clock edge with start high and busy low.
//   busy stays low, so a new matrix may enter in every cycle.
//   each result shows on b00..b22, determinant, singular and overflow for
//   exactly one cycle, marked by done.
//   throughput is one matrix per cycle; the depth is set by the restoring
//   divider, which resolves one quotient bit per stage for 33 stages, after
//   seven stages of products, cofactors and determinant and one setup stage.
//   a singular matrix gives zero outputs with singular set; values beyond
//   the format saturate and set overflow.
//   reset clears the valid bits of every stage, so transactions in flight
//   are dropped and done stays low until new ones arrive.
//   the receiver cannot stall: results are not held.
// ------------------------------------------------------------------------
module matrix3x3_inverse (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] a00,
    input  logic [31:0] a01,
    input  logic [31:0] a02,
    input  logic [31:0] a10,
    input  logic [31:0] a11,
    input  logic [31:0] a12,
    input  logic [31:0] a20,
    input  logic [31:0] a21,
    input  logic [31:0] a22,
    output logic        done,
    output logic [31:0] b00,
    output logic [31:0] b01,
    output logic [31:0] b02,
    output logic [31:0] b10,
    output logic [31:0] b11,
    output logic [31:0] b12,
    output logic [31:0] b20,
    output logic [31:0] b21,
    output logic [31:0] b22,
    output logic [31:0] determinant,
    output logic        singular,
    output logic        overflow
);
    import m3inv_pkg::*;

    localparam logic [DATA_W:0] LIM_POS = {2'b00, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W:0] LIM_NEG = {2'b01, {(DATA_W-1){1'b0}}};

    // valid bits
    logic [LATENCY-1:0] vld_reg, vld_next;

    // stage 1: element products
    logic signed [PROD_W-1:0] pp_reg [NELEM], pp_next [NELEM];
    logic signed [PROD_W-1:0] pq_reg [NELEM], pq_next [NELEM];
    logic signed [DATA_W-1:0] top1_reg [3];
    // stage 2: cofactors
    logic signed [COF_W-1:0]  cof_reg [NELEM], cof_next [NELEM];
    logic signed [DATA_W-1:0] top2_reg [3];
    // stage 3: magnitudes and signs
    logic [MAG_W-1:0]  cm3_reg [NELEM], cm3_next [NELEM];
    logic [NELEM-1:0]  cn3_reg, cn3_next;
    logic [DATA_W-1:0] am_reg [3], am_next [3];
    logic [2:0]        an_reg, an_next;
    // stage 4: partial products of the determinant terms
    logic [PROD_W-1:0] pl_reg [3], pl_next [3];
    logic [PROD_W-1:0] ph_reg [3], ph_next [3];
    logic [2:0]        tn_reg, tn_next;
    logic [MAG_W-1:0]  cm4_reg [NELEM];
    logic [NELEM-1:0]  cn4_reg;
    // stage 5: signed terms
    logic [DET_W-1:0]  term_reg [3], term_next [3];
    logic [MAG_W-1:0]  cm5_reg [NELEM];
    logic [NELEM-1:0]  cn5_reg;
    // stage 6: determinant
    logic [DET_W-1:0]  det_reg, det_next;
    logic [MAG_W-1:0]  cm6_reg [NELEM];
    logic [NELEM-1:0]  cn6_reg;
    // stage 7: dividends, divisor, rounded determinant
    logic [WIDE-1:0]   num_reg [NELEM], num_next [NELEM];
    logic [NELEM-1:0]  in7_reg, in7_next;
    logic [D2_W-1:0]   d27_reg, d27_next;
    logic              dn7_reg, dn7_next;
    logic [DATA_W-1:0] dq7_reg, dq7_next;
    logic              dov7_reg, dov7_next;
    logic              sg7_reg, sg7_next;
    // divider stages
    div_stage_t div_reg [QB+1];
    div_stage_t div_next [QB+1];
    // output register
    logic [DATA_W-1:0] b_reg [NELEM], b_next [NELEM];
    logic [DATA_W-1:0] det_out_reg, det_out_next;
    logic              sing_out_reg, sing_out_next;
    logic              ov_out_reg, ov_out_next;

    logic signed [DATA_W-1:0] a_in [NELEM];

    assign busy = 1'b0;

    always_comb
    begin
        a_in[0] = a00; a_in[1] = a01; a_in[2] = a02;
        a_in[3] = a10; a_in[4] = a11; a_in[5] = a12;
        a_in[6] = a20; a_in[7] = a21; a_in[8] = a22;
    end

    // valid shift line
    assign vld_next = {vld_reg[LATENCY-2:0], start & ~busy};

    // stage 1: the two products of each cofactor
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pp_next[r*3+c] = PROD_W'(a_in[((r+1)%3)*3 + (c+1)%3])
                               * PROD_W'(a_in[((r+2)%3)*3 + (c+2)%3]);
                pq_next[r*3+c] = PROD_W'(a_in[((r+1)%3)*3 + (c+2)%3])
                               * PROD_W'(a_in[((r+2)%3)*3 + (c+1)%3]);
            end
        end
    end

    // stage 2: cofactors, exact
    always_comb
    begin
        for (int i = 0; i < NELEM; i++)
        begin
            cof_next[i] = COF_W'(pp_reg[i]) - COF_W'(pq_reg[i]);
        end
    end

    // stage 3: sign and magnitude
    always_comb
    begin
        logic [COF_W-1:0] neg_cof;
        neg_cof = '0;
        for (int i = 0; i < NELEM; i++)
        begin
            cn3_next[i] = cof_reg[i][COF_W-1];
            neg_cof     = COF_W'(-cof_reg[i]);
            cm3_next[i] = cn3_next[i] ? neg_cof[MAG_W-1:0] : cof_reg[i][MAG_W-1:0];
        end
        for (int c = 0; c < 3; c++)
        begin
            an_next[c] = top2_reg[c][DATA_W-1];
            am_next[c] = an_next[c] ? DATA_W'(-top2_reg[c]) : DATA_W'(top2_reg[c]);
        end
    end

    // stage 4: 64 by 32 products split in halves
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pl_next[c] = PROD_W'(cm3_reg[c][DATA_W-1:0]) * PROD_W'(am_reg[c]);
            ph_next[c] = PROD_W'(cm3_reg[c][MAG_W-1:DATA_W]) * PROD_W'(am_reg[c]);
            tn_next[c] = an_reg[c] ^ cn3_reg[c];
        end
    end

    // stage 5: recombine halves and apply sign
    always_comb
    begin
        logic [DET_W-1:0] t;
        t = '0;
        for (int c = 0; c < 3; c++)
        begin
            t = DET_W'({ph_reg[c], {DATA_W{1'b0}}}) + DET_W'(pl_reg[c]);
            term_next[c] = tn_reg[c] ? DET_W'(-t) : t;
        end
    end

    // stage 6: determinant sum
    assign det_next = term_reg[0] + term_reg[1] + term_reg[2];

    // stage 7: magnitude, rounded determinant, transposed dividends
    always_comb
    begin
        logic [DMAG_W-1:0] dmag;
        logic [DET_W-1:0]  neg_det;
        logic [DET_W-1:0]  rd;
        logic [DET_W-1:0]  lim;
        neg_det  = DET_W'(-det_reg);
        dn7_next = det_reg[DET_W-1];
        sg7_next = (det_reg == '0);
        dmag     = dn7_next ? neg_det[DMAG_W-1:0] : det_reg[DMAG_W-1:0];
        rd       = (DET_W'(dmag) + (DET_W'(1) << (2*FRAC_BITS-1))) >> (2*FRAC_BITS);
        lim      = dn7_next ? DET_W'(LIM_NEG) : DET_W'(LIM_POS);
        dov7_next = (rd > lim);
        dq7_next  = dov7_next ? lim[DATA_W-1:0] : rd[DATA_W-1:0];
        if (dn7_next)
        begin
            dq7_next = DATA_W'(-dq7_next);
        end
        d27_next = {dmag, 1'b0};
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                num_next[r*3+c] = (WIDE'(cm6_reg[c*3+r]) << NSH) + WIDE'(dmag);
                in7_next[r*3+c] = cn6_reg[c*3+r];
            end
        end
    end

    // divider setup, then restoring divider with one quotient bit per stage;
    // quotients past the counted bits saturate
    always_comb
    begin
        logic [WIDE-1:0] dsh;
        dsh = '0;
        div_next[0].d2     = d27_reg;
        div_next[0].dneg   = dn7_reg;
        div_next[0].det_q  = dq7_reg;
        div_next[0].det_ov = dov7_reg;
        div_next[0].sing   = sg7_reg;
        div_next[0].ineg   = in7_reg;
        div_next[0].quo    = '0;
        for (int j = 0; j < NELEM; j++)
        begin
            div_next[0].rem[j] = num_reg[j];
            div_next[0].big[j] = (num_reg[j] >= (WIDE'(d27_reg) << QB));
        end
        for (int k = 1; k <= QB; k++)
        begin
            div_next[k] = div_reg[k-1];
            dsh = WIDE'(div_reg[k-1].d2) << (QB - k);
            for (int j = 0; j < NELEM; j++)
            begin
                if (div_reg[k-1].rem[j] >= dsh)
                begin
                    div_next[k].rem[j]        = div_reg[k-1].rem[j] - dsh;
                    div_next[k].quo[j][QB-k]  = 1'b1;
                end
            end
        end
    end

    // saturate, sign and zero on singular
    always_comb
    begin
        logic              neg;
        logic              sat;
        logic              any_ov;
        logic [DATA_W:0]   lim;
        logic [DATA_W:0]   m;
        div_stage_t        s;
        s      = div_reg[QB];
        any_ov = s.det_ov;
        neg    = 1'b0;
        sat    = 1'b0;
        lim    = '0;
        m      = '0;
        for (int j = 0; j < NELEM; j++)
        begin
            neg = (s.ineg[j] ^ s.dneg) & (s.big[j] | (s.quo[j] != '0));
            lim = neg ? LIM_NEG : LIM_POS;
            sat = s.big[j] | (s.quo[j] > lim);
            m   = sat ? lim : s.quo[j];
            any_ov = any_ov | sat;
            b_next[j] = neg ? DATA_W'(-m) : m[DATA_W-1:0];
            if (s.sing)
            begin
                b_next[j] = '0;
            end
        end
        det_out_next  = s.sing ? '0 : s.det_q;
        sing_out_next = vld_reg[LATENCY-2] & s.sing;
        ov_out_next   = vld_reg[LATENCY-2] & ~s.sing & any_ov;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            sing_out_reg <= 1'b0;
            ov_out_reg   <= 1'b0;
        end
        else
        begin
            vld_reg      <= vld_next;
            sing_out_reg <= sing_out_next;
            ov_out_reg   <= ov_out_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NELEM; i++)
        begin
            pp_reg[i]  <= pp_next[i];
            pq_reg[i]  <= pq_next[i];
            cof_reg[i] <= cof_next[i];
            cm3_reg[i] <= cm3_next[i];
            cm4_reg[i] <= cm3_reg[i];
            cm5_reg[i] <= cm4_reg[i];
            cm6_reg[i] <= cm5_reg[i];
            num_reg[i] <= num_next[i];
            b_reg[i]   <= b_next[i];
        end
        for (int c = 0; c < 3; c++)
        begin
            top1_reg[c] <= a_in[c];
            top2_reg[c] <= top1_reg[c];
            am_reg[c]   <= am_next[c];
            pl_reg[c]   <= pl_next[c];
            ph_reg[c]   <= ph_next[c];
            term_reg[c] <= term_next[c];
        end
        an_reg   <= an_next;
        cn3_reg  <= cn3_next;
        tn_reg   <= tn_next;
        cn4_reg  <= cn3_reg;
        cn5_reg  <= cn4_reg;
        cn6_reg  <= cn5_reg;
        det_reg  <= det_next;
        in7_reg  <= in7_next;
        d27_reg  <= d27_next;
        dn7_reg  <= dn7_next;
        dq7_reg  <= dq7_next;
        dov7_reg <= dov7_next;
        sg7_reg  <= sg7_next;
        for (int k = 0; k <= QB; k++)
        begin
            div_reg[k] <= div_next[k];
        end
        det_out_reg <= det_out_next;
    end

    // outputs
    assign done        = vld_reg[LATENCY-1];
    assign b00         = b_reg[0];
    assign b01         = b_reg[1];
    assign b02         = b_reg[2];
    assign b10         = b_reg[3];
    assign b11         = b_reg[4];
    assign b12         = b_reg[5];
    assign b20         = b_reg[6];
    assign b21         = b_reg[7];
    assign b22         = b_reg[8];
    assign determinant = det_out_reg;
    assign singular    = sing_out_reg;
    assign overflow    = ov_out_reg;

endmodule

// File: hdl/m3inv_checker.sv
// ------------------------------------------------------------------------
// m3inv_checker
// port-level timing and flag checks for the 3x3 matrix inverse
// ------------------------------------------------------------------------
`include "matrix3x3_inverse_defines.svh"

module m3inv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        singular,
    input logic        overflow,
    input logic [31:0] determinant,
    input logic [31:0] b00
);
    import m3inv_pkg::*;

    // every transaction returns after the fixed latency
    `M3_CHECK_DLY(a_lat_fwd, start && !busy, LATENCY, done, "result missing after latency")

    // no result without a transaction that fed it
    `M3_CHECK(a_lat_back, done, $past(start && !busy, LATENCY), "result without transaction")

    // singular result has zero determinant and b00 with no overflow
    `M3_CHECK(a_sing_zero, done && singular, determinant == 32'd0 && b00 == 32'd0 && !overflow, "singular result not cleared")

    // flags only show with a result
    `M3_CHECK(a_flag_idle, !done, !singular && !overflow, "flag raised without result")

endmodule

bind matrix3x3_inverse m3inv_checker u_m3inv_checker (.*);

// File: bench/matrix3x3_inverse_test.sv
// ------------------------------------------------------------------------
// matrix3x3_inverse_test
// self-checking bench for the pipelined 3x3 matrix inverse: a queue-fed
// driver sends matrices, a predictor forms the exact expected inverse,
// determinant and flags, and a monitor compares every result in order
// ------------------------------------------------------------------------
module matrix3x3_inverse_test;
    import m3inv_pkg::*;

    localparam int WD       = 200;
    localparam int WDOG_MAX = 2000;

    typedef logic [DATA_W-1:0] elem_t;

    typedef struct {
        elem_t a [NELEM];
    } matrix_t;

    typedef struct {
        elem_t b [NELEM];
        elem_t det;
        logic  sing;
        logic  ovf;
    } inverse_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    elem_t a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0;
    elem_t a12 = '0, a20 = '0, a21 = '0, a22 = '0;
    logic  done;
    elem_t b00, b01, b02, b10, b11, b12, b20, b21, b22, determinant;
    logic  singular, overflow;

    matrix_t  pending_mats [$];
    inverse_t expected_invs [$];
    int       idle_pct = 0;
    int       mismatches = 0;
    int       wdog = 0;
    bit       taken = 1'b0;
    bit       timed_out = 1'b0;

    matrix3x3_inverse u_top (.*);

    always #5 clk = ~clk;

    // saturate a sign and magnitude to a 32-bit code
    function automatic elem_t sat_code(input bit neg, input logic [WD-1:0] mag,
                                       inout bit ovf);
        logic [WD-1:0] lim;
        lim = neg ? WD'(64'h8000_0000) : WD'(64'h7FFF_FFFF);
        if (mag > lim)
        begin
            ovf = 1'b1;
            mag = lim;
        end
        return neg ? elem_t'(-mag) : elem_t'(mag);
    endfunction

    // exact adjugate over determinant, rounded half away from zero
    function automatic inverse_t invert(input matrix_t m);
        logic signed [WD-1:0] x [NELEM];
        logic signed [WD-1:0] cof [NELEM];
        logic signed [WD-1:0] det;
        logic [WD-1:0] dmag, num, quo, cmag;
        bit dneg, ovf, neg;
        int r1, r2, c1, c2;
        inverse_t res;
        ovf = 1'b0;
        for (int i = 0; i < NELEM; i++) x[i] = WD'($signed(m.a[i]));
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                r1 = (r + 1) % 3; r2 = (r + 2) % 3;
                c1 = (c + 1) % 3; c2 = (c + 2) % 3;
                cof[r*3+c] = x[r1*3+c1] * x[r2*3+c2] - x[r1*3+c2] * x[r2*3+c1];
            end
        end
        det = x[0] * cof[0] + x[1] * cof[1] + x[2] * cof[2];
        foreach (res.b[i]) res.b[i] = '0;
        res.det  = '0;
        res.sing = (det == 0);
        res.ovf  = 1'b0;
        if (res.sing) return res;
        dneg = det < 0;
        dmag = dneg ? -det : det;
        res.det = sat_code(dneg, (dmag + (WD'(1) << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS),
                           ovf);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cmag = cof[c*3+r] < 0 ? -cof[c*3+r] : cof[c*3+r];
                num  = (cmag << (2*FRAC_BITS + 1)) + dmag;
                quo  = num / (dmag << 1);
                neg  = ((cof[c*3+r] < 0) != dneg) && (quo != 0);
                res.b[r*3+c] = sat_code(neg, quo, ovf);
            end
        end
        res.ovf = ovf;
        return res;
    endfunction

    // driver: hold a transaction until taken, then next one or idle
    always @(negedge clk)
    begin
        matrix_t m;
        logic nxt;
        nxt = start && !taken;
        if (!nxt && pending_mats.size() > 0 && rst_n
            && $urandom_range(99, 0) >= idle_pct)
        begin
            m = pending_mats.pop_front();
            {a00, a01, a02, a10, a11, a12, a20, a21, a22} <=
                {m.a[0], m.a[1], m.a[2], m.a[3], m.a[4], m.a[5], m.a[6], m.a[7], m.a[8]};
            nxt = 1'b1;
        end
        start <= nxt;
    end

    // monitor: record accepted matrices, check each result against the oldest
    always @(posedge clk)
    begin
        matrix_t  m;
        inverse_t e;
        elem_t    got [NELEM];
        bit       bad;
        taken = start && !busy && rst_n;
        if (taken)
        begin
            m.a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
            expected_invs.push_back(invert(m));
        end
        if (done && rst_n)
        begin
            got = '{b00, b01, b02, b10, b11, b12, b20, b21, b22};
            if (expected_invs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("result with no transaction pending");
            end
            else
            begin
                e = expected_invs.pop_front();
                bad = (e.det != determinant) || (e.sing != singular) || (e.ovf != overflow);
                foreach (got[i]) if (got[i] != e.b[i]) bad = 1'b1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp b=%p det=%h sing=%b ovf=%b",
                                 e.b, e.det, e.sing, e.ovf);
                        $display("         got b=%p det=%h sing=%b ovf=%b",
                                 got, determinant, singular, overflow);
                    end
                end
            end
        end
        // watchdog on cycles without any transaction
        wdog = (taken || done) ? 0 : wdog + 1;
        if (wdog >= WDOG_MAX && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic matrix_t diag(input elem_t d0, input elem_t d1, input elem_t d2);
        matrix_t m;
        foreach (m.a[i]) m.a[i] = '0;
        m.a[0] = d0; m.a[4] = d1; m.a[8] = d2;
        return m;
    endfunction

    function automatic matrix_t fill(input elem_t v);
        matrix_t m;
        foreach (m.a[i]) m.a[i] = v;
        return m;
    endfunction

    // random matrix: mostly within +-4.0, some tiny, some full range, some singular
    function automatic matrix_t rand_mat();
        matrix_t m;
        int kind;
        kind = $urandom_range(99, 0);
        foreach (m.a[i])
        begin
            if (kind < 60) m.a[i] = elem_t'($urandom_range(8 << 16, 0) - (4 << 16));
            else if (kind < 75) m.a[i] = elem_t'($urandom_range(64, 0) - 32);
            else m.a[i] = $urandom;
        end
        // duplicate a row to make it singular
        if (kind >= 90) for (int c = 0; c < 3; c++) m.a[3+c] = m.a[c];
        return m;
    endfunction

    task automatic drain();
        wait (pending_mats.size() == 0 && !start && expected_invs.size() == 0);
    endtask

    initial
    begin
        matrix_t m;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed matrices
        pending_mats.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        pending_mats.push_back(fill('0));
        pending_mats.push_back(fill(32'h7FFF_FFFF));
        pending_mats.push_back(fill(32'h8000_0000));
        pending_mats.push_back(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_mats.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_mats.push_back(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000));
        pending_mats.push_back(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        pending_mats.push_back(diag(32'h0000_0100, 32'h0000_0100, 32'h0001_0000));
        pending_mats.push_back(diag(32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000));
        pending_mats.push_back(diag(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
        pending_mats.push_back(diag(32'h0003_0000, 32'h0001_0000, 32'h0001_0000));
        pending_mats.push_back(diag(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000));
        pending_mats.push_back(diag(32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
        m.a = '{32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0003_0000,
                32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0004_0000};
        pending_mats.push_back(m);
        m.a = '{32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                32'h0001_0000, 32'h0, 32'h0};
        pending_mats.push_back(m);
        m.a = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000,
                32'h0009_0000};
        pending_mats.push_back(m);
        m.a = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555,
                32'h0, 32'h0, 32'h0, 32'h0001_0000};
        pending_mats.push_back(m);
        // pause until the pipeline is empty
        drain();

        // random phases with different sender gaps
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = (p == 1) ? 51 : (p == 3) ? 27 : 0;
            repeat (110) pending_mats.push_back(rand_mat());
            drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_invs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/m3inv_pkg.sv
hdl/matrix3x3_inverse.sv
hdl/m3inv_checker.sv
bench/matrix3x3_inverse_test.sv
